// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the UTF-8 newline/escape decoder.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition");

`endif

// ===== rtl/core/u8d_pkg.sv =====
// Package for the UTF-8 newline/escape decoder: decoder state, result
// record, error codes and byte constants. No dependencies.
`default_nettype none

package u8d_pkg;

  localparam int CpWidth  = 21;
  localparam int ErrWidth = 3;

  localparam logic [ErrWidth-1:0] ERR_OK       = 3'd0;
  localparam logic [ErrWidth-1:0] ERR_STRAY    = 3'd1;
  localparam logic [ErrWidth-1:0] ERR_MISSING  = 3'd2;
  localparam logic [ErrWidth-1:0] ERR_BAD_LEAD = 3'd3;
  localparam logic [ErrWidth-1:0] ERR_TRUNC    = 3'd4;

  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

  typedef struct packed {
    logic [1:0]         followers_left;
    logic [CpWidth-1:0] partial_point;
    logic               escape_pending;
    logic               after_carriage_return;
  } dec_state_t;

  typedef struct packed {
    logic                valid;
    logic [CpWidth-1:0]  code_point;
    logic                escaped;
    logic [ErrWidth-1:0] error_code;
    logic                stream_end;
  } dec_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/u8d_step.sv =====
// Combinational decode of one byte: next decoder state and optional result.
// Depends on u8d_pkg.
`default_nettype none

module u8d_step (
  input  wire logic [7:0]          in_byte,
  input  wire logic                end_of_input,
  input  wire u8d_pkg::dec_state_t cur,
  output u8d_pkg::dec_state_t      nxt,
  output u8d_pkg::dec_result_t     res
);

  logic                         fail_en;
  logic [u8d_pkg::ErrWidth-1:0] fail_code;
  logic                         lead_seen;
  logic [u8d_pkg::CpWidth-1:0]  shifted;

  assign shifted = {cur.partial_point[u8d_pkg::CpWidth-7:0], in_byte[5:0]};

  always_comb begin
    nxt            = cur;
    fail_en        = 1'b0;
    fail_code      = u8d_pkg::ERR_OK;
    lead_seen      = 1'b0;
    res.valid      = 1'b0;
    res.code_point = '0;
    res.escaped    = 1'b0;
    res.error_code = u8d_pkg::ERR_OK;
    res.stream_end = end_of_input;

    if (cur.followers_left != 2'd0) begin
      nxt.after_carriage_return = 1'b0;
      if (in_byte[7:6] != 2'b10) begin
        fail_en   = 1'b1;
        fail_code = u8d_pkg::ERR_MISSING;
      end else begin
        nxt.partial_point  = shifted;
        nxt.followers_left = cur.followers_left - 2'd1;
        if (cur.followers_left == 2'd1) begin
          res.valid          = 1'b1;
          res.code_point     = shifted;
          res.escaped        = cur.escape_pending;
          nxt.escape_pending = 1'b0;
        end else if (end_of_input) begin
          fail_en   = 1'b1;
          fail_code = u8d_pkg::ERR_TRUNC;
        end
      end
    end else if (cur.after_carriage_return && in_byte == u8d_pkg::CHAR_LF) begin
      // LF right after an emitted CR is folded into that newline
      nxt.after_carriage_return = 1'b0;
    end else begin
      nxt.after_carriage_return = 1'b0;
      case (in_byte) inside
        8'b0???????: begin
          if (in_byte == u8d_pkg::CHAR_BACKSLASH && !cur.escape_pending) begin
            nxt.escape_pending = 1'b1;
            if (end_of_input) begin
              // trailing backslash: escaped zero
              nxt.escape_pending = 1'b0;
              res.valid          = 1'b1;
              res.escaped        = 1'b1;
            end
          end else begin
            nxt.escape_pending = 1'b0;
            res.valid          = 1'b1;
            res.escaped        = cur.escape_pending;
            if (in_byte == u8d_pkg::CHAR_CR) begin
              nxt.after_carriage_return = 1'b1;
              res.code_point = {{(u8d_pkg::CpWidth-8){1'b0}}, u8d_pkg::CHAR_LF};
            end else begin
              res.code_point = {{(u8d_pkg::CpWidth-8){1'b0}}, in_byte};
            end
          end
        end
        8'b10??????: begin
          fail_en   = 1'b1;
          fail_code = u8d_pkg::ERR_STRAY;
        end
        8'b110?????: begin
          lead_seen          = 1'b1;
          nxt.partial_point  = {{(u8d_pkg::CpWidth-5){1'b0}}, in_byte[4:0]};
          nxt.followers_left = 2'd1;
        end
        8'b1110????: begin
          lead_seen          = 1'b1;
          nxt.partial_point  = {{(u8d_pkg::CpWidth-4){1'b0}}, in_byte[3:0]};
          nxt.followers_left = 2'd2;
        end
        8'b11110???: begin
          lead_seen          = 1'b1;
          nxt.partial_point  = {{(u8d_pkg::CpWidth-3){1'b0}}, in_byte[2:0]};
          nxt.followers_left = 2'd3;
        end
        default: begin
          fail_en   = 1'b1;
          fail_code = u8d_pkg::ERR_BAD_LEAD;
        end
      endcase
      if (lead_seen && end_of_input) begin
        fail_en   = 1'b1;
        fail_code = u8d_pkg::ERR_TRUNC;
      end
    end

    if (fail_en) begin
      nxt.followers_left = 2'd0;
      nxt.partial_point  = '0;
      nxt.escape_pending = 1'b0;
      res.valid          = 1'b1;
      res.code_point     = '0;
      res.escaped        = 1'b0;
      res.error_code     = fail_code;
    end

    if (end_of_input) begin
      nxt = '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/u8d_out_reg.sv =====
// Result register of the decoder: holds one result until it is transferred.
// Depends on u8d_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module u8d_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire u8d_pkg::dec_result_t load_res,
  output logic                      can_load,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output u8d_pkg::dec_result_t      held
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      held <= load_res;
    end
  end

  `ASSERT_IMPLY(a_err_zero_payload, clk, rst,
    out_valid && held.error_code != u8d_pkg::ERR_OK,
    held.code_point == '0 && !held.escaped)
  `ASSERT_IMPLY(a_err_code_range, clk, rst, out_valid,
    held.error_code <= u8d_pkg::ERR_TRUNC)
  `ASSERT_IMPLY(a_stall_blocks_load, clk, rst, out_valid && !out_ready, !can_load)

endmodule

`default_nettype wire

// ===== rtl/core/utf8_decode_newline_escape.sv =====
// Top level of the UTF-8 decoder with newline folding and backslash escapes.
// Depends on u8d_pkg, u8d_step, u8d_out_reg and assert_macros.svh.
//
//  channel | ports                                    | transfer when
//  --------+------------------------------------------+----------------------
//  input   | in_byte, end_of_input                    | in_valid && in_ready
//  output  | code_point, escaped, error_code, stream_end | out_valid && out_ready
//
// One byte per clock while the output is not stalled; a result passes the input
// register, then the result register, before it is on the outputs.
// Decoder state updates when the registered byte is decoded; rate is set by
// the combinational decode between the input and result registers.
// Synchronous active-high reset clears both registers' valid and the state.
// A stalled output holds the input register only when that byte yields a result.
`default_nettype none
`include "assert_macros.svh"

module utf8_decode_newline_escape (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_byte,
  input  wire logic                         end_of_input,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [u8d_pkg::CpWidth-1:0]       code_point,
  output logic                              escaped,
  output logic [u8d_pkg::ErrWidth-1:0]      error_code,
  output logic                              stream_end
);

  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s1_end;
  logic                 s1_done;
  logic                 can_load;
  u8d_pkg::dec_state_t  state;
  u8d_pkg::dec_state_t  state_next;
  u8d_pkg::dec_result_t step_res;
  u8d_pkg::dec_result_t held;

  u8d_step u_step (
    .in_byte      (s1_byte),
    .end_of_input (s1_end),
    .cur          (state),
    .nxt          (state_next),
    .res          (step_res)
  );

  // byte leaves stage 1 when it has no result or the result register is free
  assign s1_done  = s1_valid && (!step_res.valid || can_load);
  assign in_ready = !s1_valid || s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      state    <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_done) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= in_byte;
      s1_end  <= end_of_input;
    end
  end

  u8d_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_valid && step_res.valid),
    .load_res  (step_res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (held)
  );

  assign code_point = held.code_point;
  assign escaped    = held.escaped;
  assign error_code = held.error_code;
  assign stream_end = held.stream_end;

  `ASSERT_IMPLY(a_follow_no_cr, clk, rst, state.followers_left != 2'd0,
    !state.after_carriage_return)
  `ASSERT_IMPLY(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  `ASSERT_IMPLY(a_end_clears_state, clk, rst, s1_done && s1_end,
    state_next == '0)

endmodule

`default_nettype wire

// ===== tb/utf8_stream_checker.sv =====
// Result checker for utf8_decode_newline_escape: watches both channels, decodes
// every accepted byte on its own and compares each result transfer in order.
// Depends on u8d_pkg for widths, error codes and byte constants.
module utf8_stream_checker
  import u8d_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                end_of_input,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [CpWidth-1:0]  code_point,
  input  logic                escaped,
  input  logic [ErrWidth-1:0] error_code,
  input  logic                stream_end,
  output int                  mismatches,
  output int                  pending,
  output int                  results_seen,
  output int                  error_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CpWidth-1:0]  cp;
    logic                esc;
    logic [ErrWidth-1:0] err;
    logic                fin;
  } char_result_t;

  char_result_t expected_chars[$];
  char_result_t oldest;

  logic [1:0]         followers_left;
  logic [CpWidth-1:0] partial_point;
  logic               escape_pending;
  logic               after_cr;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Decoder state advances once per accepted byte; at most one result queued.
  task automatic predict_byte(input logic [7:0] b, input logic last);
    char_result_t r;
    logic emit;
    logic bad;
    r = '0;
    emit = 1'b0;
    bad = 1'b0;
    if (followers_left != 2'd0) begin
      after_cr = 1'b0;
      if (b[7:6] != 2'b10) begin
        bad = 1'b1;
        r.err = ERR_MISSING;
      end else begin
        partial_point = {partial_point[CpWidth-7:0], b[5:0]};
        followers_left = followers_left - 2'd1;
        if (followers_left == 2'd0) begin
          emit = 1'b1;
          r.cp = partial_point;
          r.esc = escape_pending;
          escape_pending = 1'b0;
        end else if (last) begin
          bad = 1'b1;
          r.err = ERR_TRUNC;
        end
      end
    end else if (after_cr && b == CHAR_LF) begin
      // LF right after CR folds into the newline already emitted
      after_cr = 1'b0;
    end else begin
      after_cr = 1'b0;
      if (!b[7]) begin
        if (b == CHAR_BACKSLASH && !escape_pending) begin
          // a trailing backslash becomes an escaped zero
          escape_pending = !last;
          emit = last;
          r.esc = 1'b1;
        end else begin
          emit = 1'b1;
          r.esc = escape_pending;
          escape_pending = 1'b0;
          if (b == CHAR_CR) begin
            after_cr = 1'b1;
            r.cp = CpWidth'(CHAR_LF);
          end else begin
            r.cp = CpWidth'(b);
          end
        end
      end else if (!b[6]) begin
        bad = 1'b1;
        r.err = ERR_STRAY;
      end else begin
        casez (b[5:3])
          3'b0??: begin
            partial_point = CpWidth'(b[4:0]);
            followers_left = 2'd1;
          end
          3'b10?: begin
            partial_point = CpWidth'(b[3:0]);
            followers_left = 2'd2;
          end
          3'b110: begin
            partial_point = CpWidth'(b[2:0]);
            followers_left = 2'd3;
          end
          default: begin
            bad = 1'b1;
            r.err = ERR_BAD_LEAD;
          end
        endcase
        if (!bad && last) begin
          bad = 1'b1;
          r.err = ERR_TRUNC;
        end
      end
    end
    if (bad) begin
      followers_left = 2'd0;
      partial_point = '0;
      escape_pending = 1'b0;
      r.cp = '0;
      r.esc = 1'b0;
      emit = 1'b1;
    end
    r.fin = last;
    if (last) begin
      followers_left = 2'd0;
      partial_point = '0;
      escape_pending = 1'b0;
      after_cr = 1'b0;
    end
    if (emit) expected_chars.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      followers_left = 2'd0;
      partial_point = '0;
      escape_pending = 1'b0;
      after_cr = 1'b0;
      expected_chars.delete();
    end else begin
      // a result can never come from the byte taken at the same edge
      if (out_valid && out_ready) begin
        results_seen++;
        if (error_code != ERR_OK) error_results++;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected result cp=%h esc=%b err=%0d end=%b",
                                    code_point, escaped, error_code, stream_end));
        end else begin
          oldest = expected_chars.pop_front();
          if (code_point !== oldest.cp)
            report_mismatch($sformatf("code_point %h, expected %h", code_point, oldest.cp));
          if (escaped !== oldest.esc)
            report_mismatch($sformatf("escaped %b, expected %b (cp %h)",
                                      escaped, oldest.esc, oldest.cp));
          if (error_code !== oldest.err)
            report_mismatch($sformatf("error_code %0d, expected %0d", error_code, oldest.err));
          if (stream_end !== oldest.fin)
            report_mismatch($sformatf("stream_end %b, expected %b (cp %h)",
                                      stream_end, oldest.fin, oldest.cp));
        end
      end
      if (in_valid && in_ready) predict_byte(in_byte, end_of_input);
    end
    pending = expected_chars.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the utf8_decode_newline_escape testbench: clock, reset, byte-stream
// stimulus, output back-pressure and verdict. Depends on u8d_pkg, the decoder
// RTL and utf8_stream_checker.
module testbench;
  import u8d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget = 1350;
  localparam int IdleLimit  = 1000;
  localparam int HoldCycles = 150;
  localparam int TailCycles = 10;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_byte = 8'h00;
  logic                end_of_input = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CpWidth-1:0]  code_point;
  logic                escaped;
  logic [ErrWidth-1:0] error_code;
  logic                stream_end;

  int mismatches, pending, results_seen, error_results;
  int bytes_sent, texts_sent, holds_asked, holds_done;
  bit calm;
  logic [7:0] text_q[$];

  always #5 clk = ~clk;

  utf8_decode_newline_escape dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_byte(in_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .code_point(code_point), .escaped(escaped),
    .error_code(error_code), .stream_end(stream_end)
  );

  utf8_stream_checker result_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_byte(in_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .code_point(code_point), .escaped(escaped),
    .error_code(error_code), .stream_end(stream_end),
    .mismatches(mismatches), .pending(pending),
    .results_seen(results_seen), .error_results(error_results)
  );

  // Output side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        out_ready <= 1'b0;
        holds_done = holds_asked;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("no transfer for %0d cycles, giving up", IdleLimit);
    $display("== FAIL ==");
    $finish;
  end

  // Called at a rising edge; returns at the edge where the byte is transferred.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    end_of_input <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    texts_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] follower_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // Mostly well-formed characters; some raw noise and sequences cut short.
  task automatic add_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      text_q.push_back(8'($urandom_range(32, 126)));
    end else if (pick < 43) begin
      text_q.push_back(CHAR_CR);
    end else if (pick < 49) begin
      text_q.push_back(CHAR_LF);
    end else if (pick < 54) begin
      text_q.push_back(CHAR_CR);
      text_q.push_back(CHAR_LF);
    end else if (pick < 64) begin
      text_q.push_back(CHAR_BACKSLASH);
    end else if (pick < 73) begin
      text_q.push_back(8'hC0 | 8'($urandom_range(31)));
      text_q.push_back(follower_byte());
    end else if (pick < 80) begin
      text_q.push_back(8'hE0 | 8'($urandom_range(15)));
      repeat (2) text_q.push_back(follower_byte());
    end else if (pick < 86) begin
      text_q.push_back(8'hF0 | 8'($urandom_range(7)));
      repeat (3) text_q.push_back(follower_byte());
    end else if (pick < 94) begin
      text_q.push_back(8'($urandom_range(255)));
    end else if ($urandom_range(1) == 1) begin
      text_q.push_back(8'hE0 | 8'($urandom_range(15)));
      repeat ($urandom_range(1)) text_q.push_back(follower_byte());
    end else begin
      text_q.push_back(8'hF0 | 8'($urandom_range(7)));
      repeat ($urandom_range(2)) text_q.push_back(follower_byte());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    calm = 1'b0;

    // directed: byte extremes, newline folding, escapes, every error kind
    send_byte(8'h00, 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(CHAR_BACKSLASH, 1'b0);
    send_byte(CHAR_BACKSLASH, 1'b0);
    send_byte(CHAR_BACKSLASH, 1'b0);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    send_byte(CHAR_BACKSLASH, 1'b0);
    send_byte(CHAR_LF, 1'b0);
    // escaped four-byte character at the top of the code space
    send_byte(CHAR_BACKSLASH, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h80, 1'b0);
    // missing follower drops the escape too
    send_byte(CHAR_BACKSLASH, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(CHAR_BACKSLASH, 1'b1);
    send_byte(CHAR_CR, 1'b0);
    send_byte(CHAR_LF, 1'b1);
    send_byte(8'hC3, 1'b1);
    wait_drained();

    while (bytes_sent < ItemTarget) begin
      calm = (bytes_sent >= 600 && bytes_sent < 850);
      text_q.delete();
      repeat ($urandom_range(1, 24)) add_token();
      if (texts_sent % 17 == 5) holds_asked++;
      send_text();
      if (texts_sent % 12 == 0) wait_drained();
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d bytes in %0d texts; %0d results checked, %0d of them errors.",
             bytes_sent, texts_sent, results_seen, error_results);
    $display("Output held off %0d times for %0d cycles; input drained at text boundaries.",
             holds_done, HoldCycles);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
